[rtl/okl_pkg.sv]
// ----------------------------------------------------------------------------
// okl_pkg
// shared widths, request and status codes, and the command and status
// bundles that pass between the ordered key list controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package okl_pkg;

   // field widths
   localparam int KEY_W     = 32;
   localparam int POS_W     = 4;
   localparam int REQ_W     = 2;
   localparam int STS_W     = 3;
   localparam int COUNT_W   = 5;
   localparam int DATA_W    = 32;

   // table depth default
   localparam int CAPACITY_DEF = 16;

   // register file: byte address is 4 * index
   localparam int CSR_AW    = 3;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SORTED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUPES  = 1'b1;

   // request codes
   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_READ   = 2'd2,
      REQ_NONE   = 2'd3
   } okl_req_code_type;

   // result status codes
   typedef enum logic [STS_W-1:0] {
      STS_OK       = 3'd0,
      STS_EMPTY    = 3'd1,
      STS_NOTFOUND = 3'd2,
      STS_DUP      = 3'd3,
      STS_FULL     = 3'd4,
      STS_BADPOS   = 3'd5
   } okl_status_type;

   // memory read address source
   typedef enum logic [1:0] {
      RD_PTR   = 2'd0,
      RD_SHIFT = 2'd1,
      RD_POS   = 2'd2
   } okl_rd_src_type;

   // controller to datapath commands
   typedef struct packed {
      logic           load;
      logic           at_zero;
      logic           srch_hit;
      logic           srch_miss;
      logic           rd_inc;
      logic           shift_init;
      logic           shift_step;
      logic           ins_write;
      logic           cmp_init;
      logic           cmp_step;
      logic           cmp_done;
      logic           read_cap;
      logic           set_status;
      okl_status_type status;
      logic           emit;
      okl_rd_src_type rd_src;
   } okl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      okl_req_code_type op;
      logic             sorted;
      logic             dupes;
      logic             cnt_zero;
      logic             full;
      logic             pos_bad;
      logic             rd_end;
      logic             shift_done;
      logic             stop;
      logic             hit;
      logic             out_free;
   } okl_stat_type;

endpackage

`default_nettype wire

[rtl/okl_if.sv]
// ----------------------------------------------------------------------------
// okl_if
// valid/ready channels for request words and response words
// ----------------------------------------------------------------------------
`default_nettype none

interface okl_req_if;
   logic                              valid;
   logic                              ready;
   logic [okl_pkg::REQ_W-1:0]         req_type;
   logic signed [okl_pkg::KEY_W-1:0]  key;
   logic [okl_pkg::POS_W-1:0]         position;

   modport source (output valid, req_type, key, position, input ready);
   modport sink   (input valid, req_type, key, position, output ready);
endinterface

interface okl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [okl_pkg::STS_W-1:0]         status;
   logic signed [okl_pkg::KEY_W-1:0]  entry_value;
   logic [okl_pkg::COUNT_W-1:0]       entry_count;
   logic                              is_empty;

   modport source (output valid, status, entry_value, entry_count, is_empty, input ready);
   modport sink   (input valid, status, entry_value, entry_count, is_empty, output ready);
endinterface

`default_nettype wire

[rtl/okl_ctrl.sv]
// ----------------------------------------------------------------------------
// okl_ctrl
// sequencer for the ordered key list: search walk, insert shift, delete
// compaction, positional read and response hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module okl_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire okl_pkg::okl_stat_type stat,
   output okl_pkg::okl_cmd_type      cmd
);

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_DECIDE   = 13'b0000000000010,
      ST_SRCH_RD  = 13'b0000000000100,
      ST_SRCH_CMP = 13'b0000000001000,
      ST_POST     = 13'b0000000010000,
      ST_SHIFT_RD = 13'b0000000100000,
      ST_SHIFT_WR = 13'b0000001000000,
      ST_INS_WR   = 13'b0000010000000,
      ST_CMP_RD   = 13'b0000100000000,
      ST_CMP_WR   = 13'b0001000000000,
      ST_READ_RD  = 13'b0010000000000,
      ST_READ_CAP = 13'b0100000000000,
      ST_FINISH   = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.status = okl_pkg::STS_OK;
      cmd.rd_src = okl_pkg::RD_PTR;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            case (stat.op)
               okl_pkg::REQ_INSERT: begin
                  if (!stat.sorted && stat.dupes) begin
                     cmd.at_zero = 1'b1;
                     state_in    = ST_POST;
                  end else begin
                     state_in = ST_SRCH_RD;
                  end
               end
               okl_pkg::REQ_DELETE: begin
                  if (stat.cnt_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = okl_pkg::STS_EMPTY;
                     state_in       = ST_FINISH;
                  end else begin
                     state_in = ST_SRCH_RD;
                  end
               end
               okl_pkg::REQ_READ: begin
                  if (stat.pos_bad) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = okl_pkg::STS_BADPOS;
                     state_in       = ST_FINISH;
                  end else begin
                     state_in = ST_READ_RD;
                  end
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end
         // search walk: fetch one entry, then compare
         ST_SRCH_RD: begin
            cmd.rd_src = okl_pkg::RD_PTR;
            if (stat.rd_end) begin
               cmd.srch_miss = 1'b1;
               state_in      = ST_POST;
            end else begin
               state_in = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (stat.stop) begin
               cmd.srch_hit = 1'b1;
               state_in     = ST_POST;
            end else begin
               cmd.rd_inc = 1'b1;
               state_in   = ST_SRCH_RD;
            end
         end
         ST_POST: begin
            if (stat.op == okl_pkg::REQ_INSERT) begin
               if (!stat.dupes && stat.hit) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = okl_pkg::STS_DUP;
                  state_in       = ST_FINISH;
               end else if (stat.full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = okl_pkg::STS_FULL;
                  state_in       = ST_FINISH;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = ST_SHIFT_RD;
               end
            end else begin
               if (!stat.hit) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = okl_pkg::STS_NOTFOUND;
                  state_in       = ST_FINISH;
               end else begin
                  cmd.cmp_init = 1'b1;
                  state_in     = ST_CMP_RD;
               end
            end
         end
         // insert: move entries up one slot from the tail down to the gap
         ST_SHIFT_RD: begin
            cmd.rd_src = okl_pkg::RD_SHIFT;
            if (stat.shift_done) begin
               state_in = ST_INS_WR;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.shift_step = 1'b1;
            state_in       = ST_SHIFT_RD;
         end
         ST_INS_WR: begin
            cmd.ins_write = 1'b1;
            state_in      = ST_FINISH;
         end
         // delete: compact the tail from the match onward
         ST_CMP_RD: begin
            cmd.rd_src = okl_pkg::RD_PTR;
            if (stat.rd_end) begin
               cmd.cmp_done = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_CMP_WR;
            end
         end
         ST_CMP_WR: begin
            cmd.cmp_step = 1'b1;
            state_in     = ST_CMP_RD;
         end
         // positional read
         ST_READ_RD: begin
            cmd.rd_src = okl_pkg::RD_POS;
            state_in   = ST_READ_CAP;
         end
         ST_READ_CAP: begin
            cmd.read_cap = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/okl_dp.sv]
// ----------------------------------------------------------------------------
// okl_dp
// key store memory, walk pointers, compare unit and response register of
// the ordered key list
// ----------------------------------------------------------------------------
`default_nettype none

module okl_dp #(
   parameter int CAPACITY = okl_pkg::CAPACITY_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               sorted_mode,
   input  wire logic                               allow_dupes,
   input  wire logic [okl_pkg::REQ_W-1:0]          req_type,
   input  wire logic signed [okl_pkg::KEY_W-1:0]   req_key,
   input  wire logic [okl_pkg::POS_W-1:0]          req_position,
   input  wire okl_pkg::okl_cmd_type               cmd,
   output okl_pkg::okl_stat_type                   stat,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_valid,
   output logic [okl_pkg::STS_W-1:0]               rsp_status,
   output logic signed [okl_pkg::KEY_W-1:0]        rsp_entry_value,
   output logic [okl_pkg::COUNT_W-1:0]             rsp_entry_count,
   output logic                                    rsp_is_empty
);

   localparam int KEY_W  = okl_pkg::KEY_W;
   localparam int POS_W  = okl_pkg::POS_W;
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PCMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // key store
   logic [KEY_W-1:0] mem [CAPACITY];
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [KEY_W-1:0] mem_wdata;
   logic [IDX_W-1:0] mem_raddr;
   logic signed [KEY_W-1:0] rd_q_ff;

   // request and walk state
   logic signed [KEY_W-1:0]   key_ff, key_in;
   okl_pkg::okl_req_code_type op_ff, op_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]          at_ff, at_in;
   logic                      hit_ff, hit_in;
   logic                      run_ff, run_in;
   okl_pkg::okl_status_type   sts_ff, sts_in;
   logic signed [KEY_W-1:0]   val_ff, val_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   okl_pkg::okl_status_type       rsp_status_ff;
   logic signed [KEY_W-1:0]       rsp_value_ff;
   logic [okl_pkg::COUNT_W-1:0]   rsp_count_ff;
   logic                          rsp_empty_ff;

   logic             eq;
   logic             lt;
   logic             skip;
   logic             out_free;
   logic [CNT_W-1:0] wr_m1;

   // compare unit
   assign eq    = (rd_q_ff == key_ff);
   assign lt    = (rd_q_ff < key_ff);
   assign wr_m1 = wr_ptr_ff - 1'b1;

   // entry dropped by compaction: the match itself, or later equal keys
   assign skip = (rd_ptr_ff == at_ff) ||
                 (allow_dupes && eq && (!sorted_mode || run_ff));

   assign out_free = !rsp_valid_ff || rsp_ready;

   // status toward the controller
   always_comb begin
      stat.op         = op_ff;
      stat.sorted     = sorted_mode;
      stat.dupes      = allow_dupes;
      stat.cnt_zero   = (cnt_ff == '0);
      stat.full       = (cnt_ff >= CNT_W'(CAPACITY));
      stat.pos_bad    = (PCMP_W'(pos_ff) >= PCMP_W'(cnt_ff));
      stat.rd_end     = (rd_ptr_ff == cnt_ff);
      stat.shift_done = (wr_ptr_ff == at_ff);
      stat.stop       = sorted_mode ? !lt : eq;
      stat.hit        = hit_ff;
      stat.out_free   = out_free;
   end

   // memory port selects
   always_comb begin
      mem_we    = cmd.shift_step || cmd.ins_write || (cmd.cmp_step && !skip);
      mem_waddr = cmd.ins_write ? at_ff[IDX_W-1:0] : wr_ptr_ff[IDX_W-1:0];
      mem_wdata = cmd.ins_write ? key_ff : rd_q_ff;
      case (cmd.rd_src)
         okl_pkg::RD_SHIFT: mem_raddr = wr_m1[IDX_W-1:0];
         okl_pkg::RD_POS:   mem_raddr = IDX_W'(pos_ff);
         default:           mem_raddr = rd_ptr_ff[IDX_W-1:0];
      endcase
   end

   // key store with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_raddr];
   end

   // walk state next values
   always_comb begin
      key_in    = key_ff;
      op_in     = op_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      at_in     = at_ff;
      hit_in    = hit_ff;
      run_in    = run_ff;
      sts_in    = sts_ff;
      val_in    = val_ff;
      if (cmd.load) begin
         key_in    = req_key;
         op_in     = okl_pkg::okl_req_code_type'(req_type);
         pos_in    = req_position;
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         hit_in    = 1'b0;
         run_in    = 1'b1;
         sts_in    = okl_pkg::STS_OK;
         val_in    = '0;
      end
      if (cmd.at_zero) begin
         at_in  = '0;
         hit_in = 1'b0;
      end
      if (cmd.srch_hit) begin
         at_in  = rd_ptr_ff;
         hit_in = eq;
      end
      if (cmd.srch_miss) begin
         at_in  = cnt_ff;
         hit_in = 1'b0;
      end
      if (cmd.rd_inc) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (cmd.shift_init) begin
         wr_ptr_in = cnt_ff;
      end
      if (cmd.shift_step) begin
         wr_ptr_in = wr_m1;
      end
      if (cmd.ins_write) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.cmp_init) begin
         rd_ptr_in = at_ff;
         wr_ptr_in = at_ff;
         run_in    = 1'b1;
      end
      if (cmd.cmp_step) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         if (!skip) begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
            run_in    = 1'b0;
         end
      end
      if (cmd.cmp_done) begin
         cnt_in = wr_ptr_ff;
      end
      if (cmd.read_cap) begin
         val_in = rd_q_ff;
      end
      if (cmd.set_status) begin
         sts_in = cmd.status;
      end
   end

   // walk state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         at_ff     <= '0;
         hit_ff    <= 1'b0;
         run_ff    <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         at_ff     <= at_in;
         hit_ff    <= hit_in;
         run_ff    <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      op_ff  <= op_in;
      pos_ff <= pos_in;
      sts_ff <= sts_in;
      val_ff <= val_in;
   end

   // response word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= sts_ff;
         rsp_value_ff  <= val_ff;
         rsp_count_ff  <= okl_pkg::COUNT_W'(cnt_ff);
         rsp_empty_ff  <= (cnt_ff == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_compact_order: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_step |-> wr_ptr_ff <= rd_ptr_ff)
      else $error("compaction write pointer passed read pointer");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("response overwritten before taken");

   a_ins_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("insert did not grow the count by one");

endmodule

`default_nettype wire

[rtl/ordered_key_list_table.sv]
// ----------------------------------------------------------------------------
// ordered_key_list_table
// bounded table of signed keys, kept sorted or in arrival order, with
// duplicates allowed or refused; insert, delete and read-at-position
//
//   channel   dir   handshake           word
//   req_if    in    valid/ready         req_type, key, position
//   rsp_if    out   valid/ready         status, entry_value, entry_count, is_empty
//   apb       in    psel/penable/pready sorted_mode at 0x0, allow_dupes at 0x4
//
// one request at a time; the key store is a single memory with one read and
// one write port, so each entry visited or moved takes a fetch and then a
// compare or a write back
// synchronous reset empties the table and clears both mode registers
// a response word waits in its register while the next request is taken;
// the finished request holds until that register frees
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_list_table #(
   parameter int CAPACITY = okl_pkg::CAPACITY_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   okl_req_if.sink                            req_if,
   okl_rsp_if.source                          rsp_if,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [okl_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [okl_pkg::DATA_W-1:0]    pwdata,
   output logic [okl_pkg::DATA_W-1:0]         prdata,
   output logic                               pready
);

   logic                              sorted_mode_ff, sorted_mode_in;
   logic                              allow_dupes_ff, allow_dupes_in;
   logic [okl_pkg::CSR_IDX_W-1:0]     csr_idx;
   logic                              csr_wr;
   okl_pkg::okl_cmd_type              cmd;
   okl_pkg::okl_stat_type             stat;

   // register decode
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[okl_pkg::CSR_AW-1:2];

   always_comb begin
      sorted_mode_in = sorted_mode_ff;
      allow_dupes_in = allow_dupes_ff;
      prdata         = '0;
      unique case (csr_idx)
         okl_pkg::CSR_SORTED: begin
            prdata = {{(okl_pkg::DATA_W-1){1'b0}}, sorted_mode_ff};
            if (csr_wr) begin
               sorted_mode_in = pwdata[0];
            end
         end
         okl_pkg::CSR_DUPES: begin
            prdata = {{(okl_pkg::DATA_W-1){1'b0}}, allow_dupes_ff};
            if (csr_wr) begin
               allow_dupes_in = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sorted_mode_ff <= 1'b0;
         allow_dupes_ff <= 1'b0;
      end else begin
         sorted_mode_ff <= sorted_mode_in;
         allow_dupes_ff <= allow_dupes_in;
      end
   end

   // sequencer
   okl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // store and datapath
   okl_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .sorted_mode     (sorted_mode_ff),
      .allow_dupes     (allow_dupes_ff),
      .req_type        (req_if.req_type),
      .req_key         (req_if.key),
      .req_position    (req_if.position),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_status      (rsp_if.status),
      .rsp_entry_value (rsp_if.entry_value),
      .rsp_entry_count (rsp_if.entry_count),
      .rsp_is_empty    (rsp_if.is_empty)
   );

endmodule

`default_nettype wire

[bench/okl_table_checker.sv]
// ----------------------------------------------------------------------------
// okl_table_checker
// watches the request, response and register ports of the ordered key list
// table, keeps its own copy of the table and modes, predicts one response
// word per accepted request and compares every response word field by field
// ----------------------------------------------------------------------------

module okl_table_checker #(
   parameter int CAPACITY = okl_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   okl_req_if                                req_mon,
   okl_rsp_if                                rsp_mon,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [okl_pkg::CSR_AW-1:0]        paddr,
   input  logic [okl_pkg::DATA_W-1:0]        pwdata,
   input  logic                              pready,
   output int                                fail_count,
   output int                                outstanding,
   output int                                checked_count,
   output int                                refused_count
);

   // one predicted response word
   typedef struct packed {
      okl_pkg::okl_status_type           status;
      logic signed [okl_pkg::KEY_W-1:0]  value;
      logic [okl_pkg::COUNT_W-1:0]       count;
      logic                              empty;
   } table_result_type;

   // shadow of the table and of the mode registers
   logic signed [okl_pkg::KEY_W-1:0] table_keys [CAPACITY];
   int                               table_len;
   logic                             sorted_mode;
   logic                             allow_dupes;

   table_result_type        pending_results [$];
   int                      mismatches;
   int                      checked;
   int                      refused;

   // walk from the front to the stop entry; sorted mode stops at the first
   // entry not below the key, unsorted mode at the first equal entry
   function automatic int find_stop(input logic signed [okl_pkg::KEY_W-1:0] k,
                                    output bit hit);
      int i;
      i = 0;
      while (i < table_len &&
             !(sorted_mode ? (table_keys[i] >= k) : (table_keys[i] == k)))
         i++;
      hit = (i < table_len) && (table_keys[i] == k);
      return i;
   endfunction

   function automatic void drop_entry(input int at);
      int i;
      for (i = at; i < table_len - 1; i++)
         table_keys[i] = table_keys[i + 1];
      table_len--;
   endfunction

   // apply one request to the shadow table and return its response word
   function automatic table_result_type predict_table_result(
      input okl_pkg::okl_req_code_type        op,
      input logic signed [okl_pkg::KEY_W-1:0] k,
      input logic [okl_pkg::POS_W-1:0]        pos);
      table_result_type r;
      int               at;
      int               i;
      int               w;
      bit               hit;
      r.status = okl_pkg::STS_OK;
      r.value  = '0;
      hit      = 1'b0;
      case (op)
         okl_pkg::REQ_INSERT: begin
            // unsorted with duplicates always goes to the front, no search
            at = 0;
            if (sorted_mode || !allow_dupes)
               at = find_stop(k, hit);
            if (!allow_dupes && hit)
               r.status = okl_pkg::STS_DUP;
            else if (table_len >= CAPACITY)
               r.status = okl_pkg::STS_FULL;
            else begin
               for (i = table_len; i > at; i--)
                  table_keys[i] = table_keys[i - 1];
               table_keys[at] = k;
               table_len++;
            end
         end
         okl_pkg::REQ_DELETE: begin
            if (table_len == 0)
               r.status = okl_pkg::STS_EMPTY;
            else begin
               at = find_stop(k, hit);
               if (!hit)
                  r.status = okl_pkg::STS_NOTFOUND;
               else if (!allow_dupes)
                  drop_entry(at);
               else if (!sorted_mode) begin
                  // compact out every match from the first one onward
                  w = at;
                  for (i = at; i < table_len; i++)
                     if (table_keys[i] != k) begin
                        table_keys[w] = table_keys[i];
                        w++;
                     end
                  table_len = w;
               end else begin
                  // remove the run of equal keys starting at the hit
                  while (at < table_len && table_keys[at] == k)
                     drop_entry(at);
               end
            end
         end
         okl_pkg::REQ_READ: begin
            if (pos < table_len)
               r.value = table_keys[pos];
            else
               r.status = okl_pkg::STS_BADPOS;
         end
         default: ;
      endcase
      r.count = okl_pkg::COUNT_W'(table_len);
      r.empty = (table_len == 0);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
   endtask

   // register writes, response compare, then request prediction
   always @(posedge clock) begin
      table_result_type want;
      if (reset) begin
         table_len   = 0;
         sorted_mode = 1'b0;
         allow_dupes = 1'b0;
         mismatches  = 0;
         checked     = 0;
         refused     = 0;
         pending_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[okl_pkg::CSR_AW-1:2] == okl_pkg::CSR_SORTED)
               sorted_mode = pwdata[0];
            else if (paddr[okl_pkg::CSR_AW-1:2] == okl_pkg::CSR_DUPES)
               allow_dupes = pwdata[0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response word with no request outstanding, status %0d",
                        $time, rsp_mon.status);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", want.status, rsp_mon.status);
               if (rsp_mon.entry_value !== want.value)
                  report_mismatch("entry_value", want.value, rsp_mon.entry_value);
               if (rsp_mon.entry_count !== want.count)
                  report_mismatch("entry_count", want.count, rsp_mon.entry_count);
               if (rsp_mon.is_empty !== want.empty)
                  report_mismatch("is_empty", want.empty, rsp_mon.is_empty);
               checked++;
               if (want.status != okl_pkg::STS_OK)
                  refused++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            pending_results.push_back(predict_table_result(
               okl_pkg::okl_req_code_type'(req_mon.req_type), req_mon.key,
               req_mon.position));
      end
      fail_count    <= mismatches;
      outstanding   <= pending_results.size();
      checked_count <= checked;
      refused_count <= refused;
   end

endmodule

[bench/tb_ordered_key_list_table.sv]
// ----------------------------------------------------------------------------
// tb_ordered_key_list_table
// drives insert, delete and read requests into the ordered key list table
// under every combination of the sorted and duplicate modes, with random
// stalls on both channels, a long response hold-off and idle drains between
// mode changes; the checker beside the block predicts and compares
// ----------------------------------------------------------------------------

module tb_ordered_key_list_table;

   localparam int WATCHDOG_LIMIT = 1000;  // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 48;    // a full search plus shift pass
   localparam int HOLD_OFF       = 120;   // long response stall
   localparam int PHASE_WORDS    = 48;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [okl_pkg::CSR_AW-1:0]    paddr;
   logic [okl_pkg::DATA_W-1:0]    pwdata;
   logic [okl_pkg::DATA_W-1:0]    prdata;
   logic                          pready;

   okl_req_if req_ch ();
   okl_rsp_if rsp_ch ();

   int   fail_count;
   int   outstanding;
   int   checked_count;
   int   refused_count;

   bit   idle_on = 1'b1;
   bit   hold_req = 1'b0;
   int   words_sent = 0;
   int   mode_writes = 0;

   // small key pool so inserts collide and deletes hit
   logic signed [okl_pkg::KEY_W-1:0] key_pool [0:7] = '{
      32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, 32'sd1, 32'sd42, -32'sd7, 32'sd100
   };

   ordered_key_list_table #(.CAPACITY(okl_pkg::CAPACITY_DEF)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_ch),
      .rsp_if  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   okl_table_checker #(.CAPACITY(okl_pkg::CAPACITY_DEF)) table_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .refused_count (refused_count)
   );

   always #6 clock = ~clock;

   // one register write: setup cycle then access cycle
   task automatic write_csr(input logic [okl_pkg::CSR_IDX_W-1:0] idx, input logic value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {{(okl_pkg::DATA_W-1){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_modes(input logic sorted, input logic dupes);
      write_csr(okl_pkg::CSR_SORTED, sorted);
      write_csr(okl_pkg::CSR_DUPES, dupes);
      mode_writes++;
   endtask

   // offer one request word and hold it until accepted
   task automatic send_word(input okl_pkg::okl_req_code_type op,
                            input logic signed [okl_pkg::KEY_W-1:0] k,
                            input logic [okl_pkg::POS_W-1:0] pos);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.key      <= k;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   // stop offering and wait for every response, then let the block settle
   task automatic drain_table;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [okl_pkg::KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 7)];
         6, 7:             return $urandom;
         8:                return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default:          return key_pool[$urandom_range(0, 7)] ^ 32'sd1;
      endcase
   endfunction

   // one random request, weighted toward filling or emptying the table
   task automatic send_random_word(input bit filling);
      int                         pick;
      okl_pkg::okl_req_code_type  op;
      pick = $urandom_range(0, 99);
      if (pick < (filling ? 60 : 25))
         op = okl_pkg::REQ_INSERT;
      else if (pick < (filling ? 80 : 75))
         op = okl_pkg::REQ_DELETE;
      else if (pick < 97)
         op = okl_pkg::REQ_READ;
      else
         op = okl_pkg::REQ_NONE;
      send_word(op, pick_key(),
                $urandom_range(0, 1) ? okl_pkg::POS_W'($urandom_range(0, 15)) :
                                       okl_pkg::POS_W'($urandom_range(0, 3)));
   endtask

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no handshake on any port
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("ordered_key_list_table regression: fail");
      $finish;
   end

   // stimulus
   initial begin
      logic [1:0] phase_modes [0:9];
      int         phase;
      int         n;
      phase_modes = '{2'b00, 2'b10, 2'b11, 2'b01, 2'b11, 2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= okl_pkg::REQ_NONE;
      req_ch.key      <= '0;
      req_ch.position <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unsorted, duplicates refused: empty table cases, append, refusals
      set_modes(1'b0, 1'b0);
      send_word(okl_pkg::REQ_DELETE, 32'sd5, 4'd0);
      send_word(okl_pkg::REQ_READ, 32'sd0, 4'd0);
      send_word(okl_pkg::REQ_NONE, -32'sd1, 4'd15);
      send_word(okl_pkg::REQ_INSERT, 32'sh8000_0000, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sh7fff_ffff, 4'd0);
      send_word(okl_pkg::REQ_INSERT, -32'sd1, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sh8000_0000, 4'd0);
      send_word(okl_pkg::REQ_DELETE, 32'sd12345, 4'd0);
      send_word(okl_pkg::REQ_READ, 32'sd0, 4'd2);
      send_word(okl_pkg::REQ_READ, 32'sd0, 4'd15);
      send_word(okl_pkg::REQ_DELETE, 32'sh7fff_ffff, 4'd0);
      drain_table();

      // sorted with duplicates: ordered insert and removal of an equal run
      set_modes(1'b1, 1'b1);
      send_word(okl_pkg::REQ_INSERT, 32'sd3, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sd3, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sd0, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sh7fff_ffff, 4'd0);
      send_word(okl_pkg::REQ_READ, 32'sd0, 4'd0);
      send_word(okl_pkg::REQ_DELETE, 32'sd3, 4'd0);
      drain_table();

      // unsorted with duplicates: front insert, delete every match
      set_modes(1'b0, 1'b1);
      send_word(okl_pkg::REQ_INSERT, 32'sd7, 4'd0);
      send_word(okl_pkg::REQ_INSERT, 32'sd7, 4'd0);
      send_word(okl_pkg::REQ_DELETE, 32'sd7, 4'd0);
      send_word(okl_pkg::REQ_READ, 32'sd0, 4'd0);
      drain_table();

      // random phases; modes change while entries are held
      for (phase = 0; phase < 10; phase++) begin
         key_pool[6] = $urandom;
         key_pool[7] = $urandom;
         if (phase >= 8)
            idle_on = 1'b0;
         set_modes(phase_modes[phase][1], phase_modes[phase][0]);
         if (phase == 2)
            hold_req = 1'b1;
         for (n = 0; n < PHASE_WORDS; n++)
            send_random_word(phase % 2 == 0);
         drain_table();
      end

      if (outstanding != 0)
         $display("%0t: %0d responses never arrived", $time, outstanding);
      $display("covered %0d request words under %0d mode settings, all four mode pairs",
               words_sent, mode_writes);
      $display("checked %0d response words, %0d of them refusals or bad positions",
               checked_count, refused_count);
      if (fail_count == 0 && outstanding == 0)
         $display("ordered_key_list_table regression: pass");
      else
         $display("ordered_key_list_table regression: fail");
      $finish;
   end

endmodule

[ordered_key_list_table.f]
rtl/okl_pkg.sv
rtl/okl_if.sv
rtl/okl_ctrl.sv
rtl/okl_dp.sv
rtl/ordered_key_list_table.sv
bench/okl_table_checker.sv
bench/tb_ordered_key_list_table.sv
